// ===== hw/rtl/b64d_pkg.sv =====
// ============================================================================
// b64d_pkg
// Shared types, result codes and the character lookup for the base64 decoder.
// ============================================================================
`default_nettype none

package b64d_pkg;

  // result kind codes carried on the output tuser
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_OK   = 2'd1,
    KIND_FAIL = 2'd2
  } kind_e;

  localparam logic [7:0] PAD_CHAR = 8'h3d;

  // work handed from the front end to the back end for one item
  typedef struct packed {
    logic [1:0] n_data;    // data bytes to send, 0 to 3
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic       has_end;   // item closes the message
    logic       end_fail;  // closing result is a failure
  } job_t;

  // sextet of an alphabet character; bit 6 set when the character is valid
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h41 && c <= 8'h5a) begin
      v = c - 8'h41;
      return {1'b1, v[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      v = c - 8'h47;
      return {1'b1, v[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = c + 8'h04;
      return {1'b1, v[5:0]};
    end else if (c == 8'h2b) begin
      return {1'b1, 6'd62};
    end else if (c == 8'h2f) begin
      return {1'b1, 6'd63};
    end
    return 7'd0;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/b64d_front.sv =====
// ============================================================================
// b64d_front
// Accepts characters, tracks the group of four and the sticky error, and
// turns each item into a job for the back end.
// ============================================================================
`default_nettype none

module b64d_front import b64d_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,    // item taken this cycle
  input  wire logic [7:0] char_code_i,
  input  wire logic       end_i,       // last character of the message
  output job_t            job_o,
  output logic            push_o
);

  logic [1:0]  pos_q, pos_d;
  logic [17:0] held_q, held_d;
  logic        tp_q, tp_d;
  logic        err_q, err_d;

  logic [6:0] sext;
  logic       is_pad;
  logic       ch_ok;
  logic [5:0] sx;
  logic [5:0] s1, s2, s3;
  job_t       job;

  // character classification
  assign sext   = sextet_of(char_code_i);
  assign is_pad = (char_code_i == PAD_CHAR);
  assign ch_ok  = sext[6] || (is_pad && pos_q[1]);
  assign sx     = is_pad ? 6'd0 : sext[5:0];
  assign s1     = held_q[17:12];
  assign s2     = held_q[11:6];
  assign s3     = held_q[5:0];

  // group and error state update
  always_comb begin
    pos_d  = pos_q;
    held_d = held_q;
    tp_d   = tp_q;
    err_d  = err_q;
    job    = '0;
    if (!err_q) begin
      if (!ch_ok) begin
        err_d  = 1'b1;
        pos_d  = 2'd0;
        held_d = '0;
        tp_d   = 1'b0;
      end else if (pos_q != 2'd3) begin
        held_d = {held_q[11:0], sx};
        if (pos_q == 2'd2) begin
          tp_d = is_pad;
        end
        pos_d = pos_q + 2'd1;
      end else begin
        job.byte0  = {s1, s2[5:4]};
        job.byte1  = {s2[3:0], s3[5:2]};
        job.byte2  = {s3[1:0], sext[5:0]};
        job.n_data = tp_q ? 2'd1 : (is_pad ? 2'd2 : 2'd3);
        pos_d      = 2'd0;
        held_d     = '0;
        tp_d       = 1'b0;
      end
    end
    if (end_i) begin
      job.has_end  = 1'b1;
      job.end_fail = err_d || (pos_d != 2'd0);
      pos_d        = 2'd0;
      held_d       = '0;
      tp_d         = 1'b0;
      err_d        = 1'b0;
    end
  end

  assign job_o  = job;
  assign push_o = accept_i && ((job.n_data != 2'd0) || job.has_end);

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 2'd0;
      held_q <= '0;
      tp_q   <= 1'b0;
      err_q  <= 1'b0;
    end else if (accept_i) begin
      pos_q  <= pos_d;
      held_q <= held_d;
      tp_q   <= tp_d;
      err_q  <= err_d;
    end
  end

  // error stays set until the message ends
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && err_q && !end_i) |=> err_q)
    else $error("sticky error cleared inside a message");

  // a completed group always restarts the position
  a_group_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !err_q && pos_q == 2'd3) |=> pos_q == 2'd0)
    else $error("group position did not wrap");

  // no data bytes are produced while the error is set
  a_no_data_on_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && err_q) |-> job_o.n_data == 2'd0)
    else $error("data produced after an error");

endmodule

`default_nettype wire

// ===== hw/rtl/b64d_queue.sv =====
// ============================================================================
// b64d_queue
// Two-entry job queue between the front end and the back end.
// ============================================================================
`default_nettype none

module b64d_queue import b64d_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  job_t      job_i,
  output logic      full_o,
  output logic      valid_o,
  output job_t      job_o,
  input  wire logic pop_i
);

  job_t       slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = slot_q[rd_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // job storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/b64d_back.sv =====
// ============================================================================
// b64d_back
// Walks through each queued job and sends its results one per cycle while
// the receiver is ready, via an output register, keeping the per-message count.
// ============================================================================
`default_nettype none

module b64d_back import b64d_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  input  job_t             q_job_i,
  output logic             q_pop_o,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] data_byte, [23:8] byte_count
  output logic [1:0]       m_axis_tuser,   // [1:0] result_kind
  output logic             m_axis_tlast    // last_of_run
);

  localparam logic [COUNT_WIDTH-1:0] CLIP_LIM = COUNT_WIDTH'(32'h0000_ffff);

  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d, cnt_inc;
  logic [1:0]             idx_q, idx_d;
  logic                   vld_q, vld_d;
  logic [23:0]            data_q, data_d;
  logic [1:0]             user_q, user_d;
  logic                   last_q, last_d;

  logic       load;
  logic       is_data;
  logic       is_last;
  logic [2:0] total;
  logic [7:0] sel_byte;

  // clip a count to the 16-bit result field
  function automatic logic [15:0] clip16(input logic [COUNT_WIDTH-1:0] v);
    return (v > CLIP_LIM) ? 16'hffff : 16'(v);
  endfunction

  assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + COUNT_WIDTH'(1);
  assign load    = q_valid_i && (!vld_q || m_axis_tready);
  assign total   = {1'b0, q_job_i.n_data} + {2'b00, q_job_i.has_end};
  assign is_data = (idx_q < q_job_i.n_data);
  assign is_last = (({1'b0, idx_q} + 3'd1) == total);
  assign q_pop_o = load && is_last;

  // pick the byte for the current result
  always_comb begin
    unique case (idx_q)
      2'd0:    sel_byte = q_job_i.byte0;
      2'd1:    sel_byte = q_job_i.byte1;
      default: sel_byte = q_job_i.byte2;
    endcase
  end

  // build the next result and advance through the job
  always_comb begin
    vld_d  = vld_q && !m_axis_tready;
    data_d = data_q;
    user_d = user_q;
    last_d = last_q;
    cnt_d  = cnt_q;
    idx_d  = idx_q;
    if (load) begin
      vld_d  = 1'b1;
      last_d = is_last;
      idx_d  = is_last ? 2'd0 : idx_q + 2'd1;
      if (is_data) begin
        user_d = KIND_DATA;
        data_d = {clip16(cnt_inc), sel_byte};
        cnt_d  = cnt_inc;
      end else if (q_job_i.end_fail) begin
        user_d = KIND_FAIL;
        data_d = 24'd0;
        cnt_d  = '0;
      end else begin
        user_d = KIND_OK;
        data_d = {clip16(cnt_q), 8'd0};
        cnt_d  = '0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 2'd0;
      cnt_q <= '0;
    end else begin
      vld_q <= vld_d;
      idx_q <= idx_d;
      cnt_q <= cnt_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    user_q <= user_d;
    last_q <= last_d;
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = user_q;
  assign m_axis_tlast  = last_q;

  // an end result restarts the byte count
  a_cnt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tuser != KIND_DATA) |-> cnt_q == '0)
    else $error("byte count not cleared after end result");

  // the end result is always the last of its run
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != KIND_DATA) |-> m_axis_tlast)
    else $error("end result not marked last");

  // a job is only released when the queue holds one
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== hw/rtl/base64_stream_decoder_top.sv =====
// ============================================================================
// base64_stream_decoder_top
// Base64 stream decoder: one character in per item, decoded bytes and an
// end-of-message status out.
// ============================================================================
// Usage:
//   Input channel s_axis carries one character per item in tdata, with tlast
//   on the last character of a message. Output channel m_axis carries one
//   result per item: tuser is the kind (data byte, success, failure), tdata
//   holds the byte and the saturated byte count, tlast closes the results of
//   one input item. A failure result tells the receiver to drop the bytes
//   already sent for that message.
//   An accepted item's job is written into the queue at the accepting edge
//   and is loaded into the output register once the back end reaches it.
//   Throughput: one character per cycle into the front end while the queue
//   is not full; the back end sends one result per cycle while the receiver
//   is ready, so a group-closing character that ends the message yields up
//   to four results. The two-entry job queue absorbs that and fills only
//   while the back end is behind.
//   Reset clears the group state, the error, the count, the queue and the
//   output valid flag. When the receiver stalls, the output holds and the
//   queue fills; s_axis_tready drops once the queue is full.
// ============================================================================
`default_nettype none

module base64_stream_decoder_top import b64d_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  wire logic        s_axis_tlast,   // end_of_message
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] data_byte, [23:8] byte_count
  output logic [1:0]       m_axis_tuser,   // [1:0] result_kind
  output logic             m_axis_tlast    // last_of_run
);

  logic accept;
  logic push;
  logic q_full;
  logic q_valid;
  logic q_pop;
  job_t front_job;
  job_t head_job;

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // character front end
  b64d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_code_i (s_axis_tdata),
    .end_i       (s_axis_tlast),
    .job_o       (front_job),
    .push_o      (push)
  );

  // job queue
  b64d_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .full_o  (q_full),
    .valid_o (q_valid),
    .job_o   (head_job),
    .pop_i   (q_pop)
  );

  // result back end
  b64d_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_job_i       (head_job),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Drives base64_stream_decoder_top with directed and random character
// messages under random stalls on both sides, predicts every decoded byte
// and end-of-message result, and checks each result field by field.
// ============================================================================

module testbench import b64d_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 8;

  // one predicted result
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [15:0] count;
    logic        last;
  } decoded_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] char_code
  logic        s_axis_tlast = 1'b0;    // end_of_message
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;           // [7:0] data_byte, [23:8] byte_count
  logic [1:0]  m_axis_tuser;           // [1:0] result_kind
  logic        m_axis_tlast;           // last_of_run

  // decoder state mirrored by the predictor
  logic [1:0]  grp_pos;
  logic [17:0] grp_sextets;
  logic        grp_third_pad;
  logic        msg_error;
  logic [15:0] msg_bytes;

  decoded_t    expected_results[$];
  decoded_t    run_buf[4];
  int          run_len;
  logic [7:0]  msg_chars[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_sent = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  base64_stream_decoder_top #(.COUNT_WIDTH(16)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** base64_stream_decoder_top: FAILED **");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // alphabet lookup: bit 6 set for an alphabet character
  function automatic logic [6:0] sextet_value(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return {1'b1, 6'(c - "A")};
    if (c >= "a" && c <= "z") return {1'b1, 6'(c - "a" + 26)};
    if (c >= "0" && c <= "9") return {1'b1, 6'(c - "0" + 52)};
    if (c == "+") return {1'b1, 6'd62};
    if (c == "/") return {1'b1, 6'd63};
    return 7'd0;
  endfunction

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    return (v == 6'd62) ? 8'h2b : 8'h2f;
  endfunction

  function automatic void clear_message_state();
    grp_pos = '0;
    grp_sextets = '0;
    grp_third_pad = 1'b0;
    msg_error = 1'b0;
    msg_bytes = '0;
  endfunction

  // one result into the run of the current item
  function automatic void add_result(input kind_e kind, input logic [7:0] data,
                                     input logic [15:0] count);
    run_buf[run_len] = '{kind: kind, data: data, count: count, last: 1'b0};
    run_len++;
  endfunction

  function automatic void add_byte(input logic [7:0] data);
    if (msg_bytes != 16'hffff) msg_bytes++;
    add_result(KIND_DATA, data, msg_bytes);
  endfunction

  // predicts the results of one accepted character
  function automatic void decode_char(input logic [7:0] ch, input logic eom);
    logic [6:0] sx;
    logic       is_pad;
    logic [5:0] s1, s2, s3;
    sx = sextet_value(ch);
    is_pad = (ch == PAD_CHAR);
    run_len = 0;
    if (!msg_error) begin
      if (!sx[6] && !(is_pad && grp_pos >= 2)) begin
        // bad character abandons the group and poisons the message
        msg_error = 1'b1;
        grp_pos = '0;
        grp_sextets = '0;
        grp_third_pad = 1'b0;
      end else if (grp_pos < 3) begin
        grp_sextets = {grp_sextets[11:0], is_pad ? 6'd0 : sx[5:0]};
        if (grp_pos == 2) grp_third_pad = is_pad;
        grp_pos++;
      end else begin
        // fourth character closes the group
        s1 = grp_sextets[17:12];
        s2 = grp_sextets[11:6];
        s3 = grp_sextets[5:0];
        add_byte({s1, s2[5:4]});
        if (!grp_third_pad) begin
          add_byte({s2[3:0], s3[5:2]});
          if (!is_pad) add_byte({s3[1:0], sx[5:0]});
        end
        grp_pos = '0;
        grp_sextets = '0;
        grp_third_pad = 1'b0;
      end
    end
    if (eom) begin
      if (msg_error || grp_pos != 0) add_result(KIND_FAIL, 8'h00, 16'h0000);
      else add_result(KIND_OK, 8'h00, msg_bytes);
      clear_message_state();
    end
    if (run_len > 0) run_buf[run_len - 1].last = 1'b1;
    for (int i = 0; i < run_len; i++) expected_results.push_back(run_buf[i]);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // result checking
  always @(posedge clk_i) begin
    decoded_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d data %02h count %0d",
                                  m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[23:8]));
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser !== want.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", m_axis_tuser, want.kind));
        if (m_axis_tdata[7:0] !== want.data)
          report_mismatch($sformatf("data %02h, expected %02h", m_axis_tdata[7:0], want.data));
        if (m_axis_tdata[23:8] !== want.count)
          report_mismatch($sformatf("count %0d, expected %0d", m_axis_tdata[23:8],
                                    want.count));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("tlast %0b, expected %0b", m_axis_tlast, want.last));
      end
    end
  end

  // sends one character item, with random idle cycles ahead of it
  task automatic send_char(input logic [7:0] ch, input logic eom);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= 8'($urandom_range(255));
      s_axis_tlast <= 1'($urandom_range(1));
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= ch;
    s_axis_tlast <= eom;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    decode_char(ch, eom);
    items_sent++;
  endtask

  task automatic send_text(input string s, input logic eom);
    for (int i = 0; i < s.len(); i++) send_char(s[i], eom && (i == s.len() - 1));
  endtask

  // stop sending, then wait for every predicted result
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // any code that is neither an alphabet character nor the pad
  function automatic logic [7:0] bad_char();
    logic [7:0] c;
    logic [6:0] sx;
    do begin
      c = 8'($urandom_range(255));
      sx = sextet_value(c);
    end while (sx[6] || c == PAD_CHAR);
    return c;
  endfunction

  // builds a random message: mostly well formed, some broken, some noise
  task automatic make_message();
    int pick, n_groups, pad_style, pos;
    msg_chars.delete();
    pick = $urandom_range(99);
    if (pick >= 85) begin
      repeat ($urandom_range(1, 6))
        msg_chars.push_back(($urandom_range(3) == 0) ? PAD_CHAR : 8'($urandom_range(255)));
      return;
    end
    n_groups = $urandom_range(1, 4);
    for (int g = 0; g < n_groups; g++) begin
      repeat (4) msg_chars.push_back(sextet_char(6'($urandom_range(63))));
      // padding mostly on the final group, sometimes inside the message
      if (g == n_groups - 1 || $urandom_range(4) == 0) begin
        pad_style = $urandom_range(3);
        if (pad_style >= 1) msg_chars[4*g + 3] = PAD_CHAR;
        if (pad_style >= 2) msg_chars[4*g + 2] = PAD_CHAR;
        if (pad_style == 3) msg_chars[4*g + 3] = sextet_char(6'($urandom_range(63)));
      end
    end
    if (pick >= 70) begin
      if ($urandom_range(1) == 0) begin
        pos = $urandom_range(msg_chars.size() - 1);
        if (pos % 4 < 2 && $urandom_range(3) == 0) msg_chars[pos] = PAD_CHAR;
        else msg_chars[pos] = bad_char();
      end else begin
        // end in the middle of a group
        repeat ($urandom_range(1, 3)) void'(msg_chars.pop_back());
      end
    end
  endtask

  // full groups across the alphabet extremes
  task automatic test_full_groups();
    send_text("AAAA//+z", 1'b0);
    send_text("09aZ", 1'b1);
  endtask

  // padded groups inside and at the end of a message
  task automatic test_padding();
    send_text("QUI=", 1'b0);
    send_text("QQ==", 1'b0);
    send_text("QQ=A", 1'b1);
  endtask

  // bad characters, characters after an error, ends in mid-group
  task automatic test_bad_characters();
    send_char(8'h00, 1'b0);
    send_char("A", 1'b0);
    send_char(8'hff, 1'b1);
    send_text("=", 1'b1);
    send_text("A=B", 1'b1);
    send_text("AB", 1'b1);
    send_char(8'h80, 1'b1);
  endtask

  task automatic test_random_messages(input int unsigned n_items);
    int unsigned target;
    target = items_sent + n_items;
    while (items_sent < target) begin
      make_message();
      for (int i = 0; i < msg_chars.size(); i++)
        send_char(msg_chars[i], i == msg_chars.size() - 1);
    end
  endtask

  initial begin
    clear_message_state();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // sender idles a third of the time, receiver mostly stalled
    send_idle_pct = 33;
    recv_idle_pct = 86;
    test_full_groups();
    test_padding();
    test_bad_characters();
    test_random_messages(100);
    wait_drained();

    // sender mostly idle, receiver stalls a third of the time
    send_idle_pct = 86;
    recv_idle_pct = 33;
    test_random_messages(115);
    wait_drained();

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_messages(115);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    for (int i = 0; i < expected_results.size(); i++)
      report_mismatch($sformatf("result never arrived: kind %0d data %02h count %0d",
                                expected_results[i].kind, expected_results[i].data,
                                expected_results[i].count));
    if (mismatch_count == 0) begin
      $display("** base64_stream_decoder_top: PASSED **");
    end else begin
      $display("** base64_stream_decoder_top: FAILED **");
    end
    $finish;
  end

endmodule
